// File: sv/rau_pkg.sv
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int WIDE = 64;
    localparam int CNT_W = 7;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] first_numerator;
        logic [31:0] first_denominator;
        logic [31:0] second_numerator;
        logic [31:0] second_denominator;
    } t_in;

    typedef struct packed {
        logic [63:0] result_numerator;
        logic [63:0] result_denominator;
        logic        zero_denominator;
        logic        overflow;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mult;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_reduce;
        logic gcd_done;
        logic div_done;
    } t_sts;

endpackage

// File: sv/rau_if.sv
interface rau_in_if;
    import rau_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rau_out_if;
    import rau_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rau_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/rau_ctrl.sv
module rau_ctrl
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_COMB = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mult = 1'b1;
                n_state = S_COMB;
            end
            S_COMB: begin
                o_cmd.gcd_init = 1'b1;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (!i_sts.need_reduce) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: sv/rau_dp.sv
module rau_dp
    import rau_pkg::*;
(
    input  logic i_clk,
    input  t_in  i_in,
    input  logic i_reduce,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_out
);

    logic [63:0] r_an, r_ad, r_bn, r_bd;
    logic [1:0]  r_op;
    logic [63:0] r_p, r_q, r_dd;
    logic [63:0] r_num, r_den;
    logic        r_ovf, r_neg, r_red;
    logic [63:0] r_ga, r_gb;
    logic [CNT_W-1:0] r_shift;
    logic        r_ga_odd;
    logic [63:0] r_g;
    logic [63:0] r_qn, r_rn, r_qd, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic        r_ddone;
    t_out        r_out;

    function automatic logic [63:0] sext(input logic [31:0] v);
        return {{(WIDE-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // operands are sign-extended 32-bit values: a 32x32 signed product
    function automatic logic [63:0] smul(input logic [63:0] a, input logic [63:0] b);
        logic signed [31:0] sa, sb;
        logic signed [63:0] pr;
        sa = a[31:0];
        sb = b[31:0];
        pr = sa * sb;
        return pr;
    endfunction

    logic        eq_den;
    logic [63:0] m_a, m_b, m_c, m_d;
    logic [63:0] c_num, c_den;
    logic        c_ovf;
    logic [63:0] sub_ab;
    logic [64:0] trial_n, trial_d;

    always_comb begin
        eq_den = (r_ad == r_bd);
        case (r_op)
            OP_MUL: begin
                m_a = r_an; m_b = r_bn; m_c = r_ad; m_d = r_bd;
            end
            OP_DIV: begin
                m_a = r_an; m_b = r_bd; m_c = r_ad; m_d = r_bn;
            end
            default: begin
                m_a = r_an; m_b = r_bd; m_c = r_bn; m_d = r_ad;
            end
        endcase
    end

    always_comb begin
        c_ovf = 1'b0;
        case (r_op)
            OP_ADD, OP_SUB: begin
                if (eq_den) begin
                    c_den = r_ad;
                    c_num = (r_op == OP_ADD) ? r_an + r_bn : r_an - r_bn;
                end else begin
                    c_den = r_dd;
                    if (r_op == OP_ADD) begin
                        c_num = r_p + r_q;
                        c_ovf = (r_p[63] == r_q[63]) && (c_num[63] != r_p[63]);
                    end else begin
                        c_num = r_p - r_q;
                        c_ovf = (r_p[63] != r_q[63]) && (c_num[63] != r_p[63]);
                    end
                end
            end
            default: begin
                c_num = r_p;
                c_den = r_q;
            end
        endcase
    end

    assign sub_ab  = r_gb - r_ga;
    assign trial_n = {r_rn[63:0], r_qn[63]} - {1'b0, r_g};
    assign trial_d = {r_rd[63:0], r_qd[63]} - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in.opcode;
            r_an <= sext(i_in.first_numerator);
            r_ad <= sext(i_in.first_denominator);
            r_bn <= sext(i_in.second_numerator);
            r_bd <= sext(i_in.second_denominator);
            r_red <= i_reduce;
        end
        if (i_cmd.mult) begin
            r_p  <= smul(m_a, m_b);
            r_q  <= smul(m_c, m_d);
            r_dd <= smul(r_ad, r_bd);
        end
        if (i_cmd.gcd_init) begin
            r_num   <= c_num;
            r_den   <= c_den;
            r_ovf   <= c_ovf;
            r_neg   <= c_num[63] ^ c_den[63];
            r_ga    <= mag(c_num);
            r_gb    <= mag(c_den);
            r_shift <= '0;
            r_ga_odd <= 1'b0;
        end
        if (i_cmd.gcd_step) begin
            if (!r_ga_odd) begin
                if (!r_ga[0] && !r_gb[0]) begin
                    r_ga <= r_ga >> 1;
                    r_gb <= r_gb >> 1;
                    r_shift <= r_shift + 1'b1;
                end else if (!r_ga[0]) begin
                    r_ga <= r_ga >> 1;
                end else begin
                    r_ga_odd <= 1'b1;
                end
            end else if (!r_gb[0]) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga > r_gb) begin
                r_ga <= r_gb;
                r_gb <= r_ga - r_gb;
            end else begin
                r_gb <= sub_ab;
            end
        end
        if (i_cmd.div_init) begin
            r_g   <= r_ga << r_shift[5:0];
            r_qn  <= mag(r_num);
            r_qd  <= mag(r_den);
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_ddone <= 1'b0;
        end
        if (i_cmd.div_step) begin
            if (!trial_n[64]) begin
                r_rn <= trial_n[63:0];
                r_qn <= {r_qn[62:0], 1'b1};
            end else begin
                r_rn <= {r_rn[62:0], r_qn[63]};
                r_qn <= {r_qn[62:0], 1'b0};
            end
            if (!trial_d[64]) begin
                r_rd <= trial_d[63:0];
                r_qd <= {r_qd[62:0], 1'b1};
            end else begin
                r_rd <= {r_rd[62:0], r_qd[63]};
                r_qd <= {r_qd[62:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            r_ddone <= (r_cnt == CNT_W'(WIDE-1));
        end
        if (i_cmd.finish) begin
            r_out.overflow <= r_ovf;
            r_out.zero_denominator <= (r_den == 64'd0);
            if (r_den == 64'd0 || !r_red) begin
                r_out.result_numerator   <= r_num;
                r_out.result_denominator <= r_den;
            end else if (r_num == 64'd0) begin
                r_out.result_numerator   <= '0;
                r_out.result_denominator <= 64'd1;
            end else begin
                r_out.result_numerator   <= r_neg ? (64'd0 - r_qn) : r_qn;
                r_out.result_denominator <= r_qd;
            end
        end
    end

    assign o_sts.need_reduce = r_red && (r_den != 64'd0) && (r_num != 64'd0);
    assign o_sts.gcd_done    = r_ga_odd && (r_gb == 64'd0);
    assign o_sts.div_done    = r_ddone;
    assign o_out = r_out;

endmodule

// File: sv/rational_arithmetic_unit.sv
// Fraction add/subtract/multiply/divide on two 32-bit fractions, 64-bit result.
// One transaction at a time. Without reduction an item is multiplied, combined
// and output; with reduction a binary GCD loop and then a restoring divide of
// numerator and denominator by the GCD follow the combine step. The length of
// the GCD loop depends on the operands.
// Write the reduce register only while idle.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_cfg_if.sink   cfg,
    rau_in_if.sink    in_ch,
    rau_out_if.source out_ch
);

    logic r_reduce;
    t_cmd cmd;
    t_sts sts;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reduce <= 1'b1;
        end else if (cfg.valid) begin
            r_reduce <= cfg.data;
        end
    end

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rau_dp u_dp (
        .i_clk    (i_clk),
        .i_in     (in_ch.data),
        .i_reduce (r_reduce),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_out    (out_ch.data)
    );

endmodule
